// ===== rtl/core/csc_pkg.sv =====
// Shared types and constants for the connection state controller.
// No dependencies; imported by csc_engine and connection_state_controller_core.
`default_nettype none

package csc_pkg;

    localparam int WIN_W   = 32;
    localparam int IDLE_W  = 25;
    localparam int KEEP_W  = 24;
    localparam int AMT_W   = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam int GRACE_MS_DEF = 100;

    localparam logic [KEEP_W-1:0] KEEPALIVE_RESET = KEEP_W'(60000);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RECEIVE_WINDOW = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_KEEPALIVE_MS   = CFG_IDX_W'(1);

    typedef enum logic [3:0] {
        PH_CLOSED      = 4'd0,
        PH_SYN_SENT    = 4'd1,
        PH_SYN_RCVD    = 4'd2,
        PH_ESTABLISHED = 4'd3,
        PH_FIN_WAIT1   = 4'd4,
        PH_FIN_WAIT2   = 4'd5,
        PH_CLOSE_WAIT  = 4'd6,
        PH_CLOSING     = 4'd7,
        PH_LAST_ACK    = 4'd8,
        PH_TIME_WAIT   = 4'd9
    } phase_t;

    typedef enum logic [3:0] {
        OP_OPEN            = 4'd0,
        OP_SYN             = 4'd1,
        OP_SYNACK          = 4'd2,
        OP_ACK             = 4'd3,
        OP_CLOSE_REQ       = 4'd4,
        OP_FIN             = 4'd5,
        OP_PASSIVE_CLOSE   = 4'd6,
        OP_TIMEWAIT_EXPIRE = 4'd7,
        OP_RESET           = 4'd8,
        OP_TIMEOUT         = 4'd9,
        OP_REFRESH         = 4'd10,
        OP_WINDOW_UPDATE   = 4'd11,
        OP_SEND            = 4'd12,
        OP_RECEIVE         = 4'd13,
        OP_TICK            = 4'd14
    } op_t;

    typedef struct packed {
        phase_t            phase;
        logic [WIN_W-1:0]  window;
        logic [IDLE_W-1:0] idle;
    } conn_t;

    typedef struct packed {
        logic              accepted;
        phase_t            phase;
        logic [WIN_W-1:0]  window;
        logic              alive;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/connection_state_controller_core.sv =====
// Top level of the TCP-style connection state controller: request and result
// registers, connection state and configuration. Depends on csc_pkg, csc_engine.
//
//  Channel   Direction  Handshake             Payload
//  request   in         in_valid / in_stall   opcode, amount
//  result    out        out_valid / out_stall accepted, conn_state, available_window, alive
//  config    in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// One request per cycle while the result is not stalled; each request passes
// through the request register, then the state update into the result register.
// csc_engine computes the state update: phase move, 32-bit window compare and subtract, idle count.
// Reset clears the connection to closed, window and idle count to zero,
// keep-alive to 60000 ms. A stalled result holds; one further request is
// taken into the request register while it waits. cfg_ready drops while a
// request sits in the request register.
`default_nettype none

module connection_state_controller_core
    import csc_pkg::*;
#(
    parameter int GRACE_MS = GRACE_MS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [3:0]            opcode,
    input  wire logic [AMT_W-1:0]      amount,

    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic                       accepted,
    output logic [3:0]                 conn_state,
    output logic [WIN_W-1:0]           available_window,
    output logic                       alive,

    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    logic               in_valid_reg;
    op_t                op_reg;
    logic [AMT_W-1:0]   amount_reg;

    logic               out_valid_reg;
    result_t            result_reg;

    conn_t              conn_reg;
    conn_t              conn_next;
    result_t            result_next;
    logic [WIN_W-1:0]   rwin_reg;
    logic [KEEP_W-1:0]  keep_reg;

    logic               out_take;
    logic               advance;
    logic               in_take;
    logic               cfg_we;

    assign out_take = !out_valid_reg || !out_stall;
    assign advance  = in_valid_reg && out_take;
    assign in_stall = in_valid_reg && !out_take;
    assign in_take  = in_valid && !in_stall;
    assign cfg_ready = !in_valid_reg;
    assign cfg_we   = cfg_valid && cfg_ready;

    // Request register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_take)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            op_reg     <= op_t'(opcode);
            amount_reg <= amount;
        end
    end

    csc_engine #(
        .GRACE_MS (GRACE_MS)
    ) u_engine (
        .cur            (conn_reg),
        .op             (op_reg),
        .amount         (amount_reg),
        .receive_window (rwin_reg),
        .keepalive_ms   (keep_reg),
        .nxt            (conn_next),
        .res            (result_next)
    );

    // Connection state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            conn_reg.phase  <= PH_CLOSED;
            conn_reg.window <= '0;
            conn_reg.idle   <= '0;
            rwin_reg        <= '0;
            keep_reg        <= KEEPALIVE_RESET;
        end
        else if (advance)
        begin
            conn_reg <= conn_next;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_RECEIVE_WINDOW)
            begin
                rwin_reg        <= WIN_W'(cfg_data);
                conn_reg.window <= WIN_W'(cfg_data);
            end
            else if (cfg_index == CFG_KEEPALIVE_MS)
            begin
                keep_reg      <= cfg_data[KEEP_W-1:0];
                conn_reg.idle <= '0;
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_take)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            result_reg <= result_next;
    end

    assign out_valid        = out_valid_reg;
    assign accepted         = result_reg.accepted;
    assign conn_state       = result_reg.phase;
    assign available_window = result_reg.window;
    assign alive            = result_reg.alive;

    // Result reflects the state left behind by the same request
    a_result_phase: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (result_reg.phase == conn_reg.phase))
        else $error("result phase differs from connection state");

    a_result_window: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (result_reg.window == conn_reg.window))
        else $error("result window differs from connection window");

    a_reset_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && op_reg == OP_RESET) |=>
            (conn_reg.phase == PH_CLOSED && result_reg.accepted))
        else $error("reset request did not close the connection");

    a_tick_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && op_reg == OP_TICK) |=>
            ((conn_reg.idle == $past(conn_reg.idle) + IDLE_W'(1)) ||
             (&$past(conn_reg.idle) && &conn_reg.idle)))
        else $error("tick did not advance the idle count");

    a_no_cfg_clash: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |-> !advance)
        else $error("configuration write collided with a request");

endmodule

`default_nettype wire

// ===== rtl/core/csc_engine.sv =====
// Next-state and result logic for one request of the connection controller.
// Purely combinational; depends on csc_pkg.
`default_nettype none

module csc_engine
    import csc_pkg::*;
#(
    parameter int GRACE_MS = GRACE_MS_DEF
)
(
    input  wire conn_t               cur,
    input  wire op_t                 op,
    input  wire logic [AMT_W-1:0]    amount,
    input  wire logic [WIN_W-1:0]    receive_window,
    input  wire logic [KEEP_W-1:0]   keepalive_ms,
    output conn_t                    nxt,
    output result_t                  res
);

    localparam int LIMIT_W = IDLE_W + 1;

    logic              ok;
    logic [LIMIT_W-1:0] idle_limit;

    always_comb
    begin
        nxt = cur;
        ok  = 1'b0;
        unique case (op)
            OP_OPEN:
            begin
                if (cur.phase == PH_CLOSED)
                begin
                    nxt.phase = PH_SYN_SENT;
                    ok = 1'b1;
                end
            end
            OP_SYN:
            begin
                if (cur.phase == PH_CLOSED)
                begin
                    nxt.phase = PH_SYN_RCVD;
                    ok = 1'b1;
                end
            end
            OP_SYNACK:
            begin
                if (cur.phase == PH_SYN_SENT)
                begin
                    nxt.phase = PH_ESTABLISHED;
                    ok = 1'b1;
                end
            end
            OP_ACK:
            begin
                ok = 1'b1;
                unique case (cur.phase)
                    PH_SYN_RCVD: nxt.phase = PH_ESTABLISHED;
                    PH_FIN_WAIT1: nxt.phase = PH_FIN_WAIT2;
                    PH_CLOSING:  nxt.phase = PH_TIME_WAIT;
                    PH_LAST_ACK: nxt.phase = PH_CLOSED;
                    default:     ok = 1'b0;
                endcase
            end
            OP_CLOSE_REQ:
            begin
                if (cur.phase == PH_ESTABLISHED)
                begin
                    nxt.phase = PH_FIN_WAIT1;
                    ok = 1'b1;
                end
            end
            OP_FIN:
            begin
                ok = 1'b1;
                unique case (cur.phase)
                    PH_ESTABLISHED: nxt.phase = PH_CLOSE_WAIT;
                    PH_FIN_WAIT1:   nxt.phase = PH_CLOSING;
                    PH_FIN_WAIT2:   nxt.phase = PH_TIME_WAIT;
                    default:        ok = 1'b0;
                endcase
            end
            OP_PASSIVE_CLOSE:
            begin
                if (cur.phase == PH_CLOSE_WAIT)
                begin
                    nxt.phase = PH_LAST_ACK;
                    ok = 1'b1;
                end
            end
            OP_TIMEWAIT_EXPIRE:
            begin
                if (cur.phase == PH_TIME_WAIT)
                begin
                    nxt.phase = PH_CLOSED;
                    ok = 1'b1;
                end
            end
            OP_RESET:
            begin
                nxt.phase = PH_CLOSED;
                ok = 1'b1;
            end
            OP_TIMEOUT:
            begin
                // Timeout only tears down half-open or closing connections
                if (cur.phase != PH_CLOSED && cur.phase != PH_ESTABLISHED)
                begin
                    nxt.phase = PH_CLOSED;
                    ok = 1'b1;
                end
            end
            OP_REFRESH:
            begin
                nxt.idle = '0;
                ok = 1'b1;
            end
            OP_WINDOW_UPDATE:
            begin
                nxt.window = (amount < receive_window) ? amount : receive_window;
                ok = 1'b1;
            end
            OP_SEND:
            begin
                if (amount <= cur.window)
                begin
                    nxt.window = cur.window - amount;
                    nxt.idle   = '0;
                    ok = 1'b1;
                end
            end
            OP_RECEIVE:
            begin
                if (cur.phase == PH_ESTABLISHED)
                begin
                    nxt.idle = '0;
                    ok = 1'b1;
                end
            end
            OP_TICK:
            begin
                // Saturate at all ones
                if (cur.idle != {IDLE_W{1'b1}})
                    nxt.idle = cur.idle + IDLE_W'(1);
                ok = 1'b1;
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase
    end

    assign idle_limit = LIMIT_W'(keepalive_ms) + LIMIT_W'(GRACE_MS);

    always_comb
    begin
        res.accepted = ok;
        res.phase    = nxt.phase;
        res.window   = nxt.window;
        res.alive    = (LIMIT_W'(nxt.idle) <= idle_limit);
    end

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking bench for connection_state_controller_core: drives events and config writes,
// tracks state, window and idle count alongside the block and compares every result.
// Depends on csc_pkg and the core RTL.
`timescale 1ns / 1ps

module testbench;
    import csc_pkg::*;

    localparam int HALF_PERIOD = 10;
    localparam logic [3:0] OP_UNUSED = 4'd15;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = CFG_IDX_W'(3);

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [3:0]            opcode = '0;
    logic [AMT_W-1:0]      amount = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  accepted;
    logic [3:0]            conn_state;
    logic [WIN_W-1:0]      available_window;
    logic                  alive;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // connection state as the block should hold it
    phase_t            trk_phase;
    logic [WIN_W-1:0]  trk_window;
    logic [IDLE_W-1:0] trk_idle;
    logic [WIN_W-1:0]  trk_rx_window;
    logic [KEEP_W-1:0] trk_keepalive;

    result_t pending_results[$];
    int      errors = 0;
    int      burst_left = 0;
    int      gap_max = 0;
    int      hold_off_request = 0;

    connection_state_controller_core i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .opcode           (opcode),
        .amount           (amount),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .accepted         (accepted),
        .conn_state       (conn_state),
        .available_window (available_window),
        .alive            (alive),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always #HALF_PERIOD clk = ~clk;

    function automatic void reset_tracking();
        trk_phase     = PH_CLOSED;
        trk_window    = '0;
        trk_idle      = '0;
        trk_rx_window = '0;
        trk_keepalive = KEEPALIVE_RESET;
    endfunction

    function automatic bit move_if(phase_t from, phase_t to);
        if (trk_phase != from)
            return 1'b0;
        trk_phase = to;
        return 1'b1;
    endfunction

    function automatic result_t apply_event(logic [3:0] op, logic [AMT_W-1:0] amt);
        result_t res;
        bit      ok;
        ok = 1'b0;
        case (op)
            OP_OPEN:            ok = move_if(PH_CLOSED, PH_SYN_SENT);
            OP_SYN:             ok = move_if(PH_CLOSED, PH_SYN_RCVD);
            OP_SYNACK:          ok = move_if(PH_SYN_SENT, PH_ESTABLISHED);
            OP_ACK:             ok = move_if(PH_SYN_RCVD, PH_ESTABLISHED) ||
                                     move_if(PH_FIN_WAIT1, PH_FIN_WAIT2) ||
                                     move_if(PH_CLOSING, PH_TIME_WAIT) ||
                                     move_if(PH_LAST_ACK, PH_CLOSED);
            OP_CLOSE_REQ:       ok = move_if(PH_ESTABLISHED, PH_FIN_WAIT1);
            OP_FIN:             ok = move_if(PH_ESTABLISHED, PH_CLOSE_WAIT) ||
                                     move_if(PH_FIN_WAIT1, PH_CLOSING) ||
                                     move_if(PH_FIN_WAIT2, PH_TIME_WAIT);
            OP_PASSIVE_CLOSE:   ok = move_if(PH_CLOSE_WAIT, PH_LAST_ACK);
            OP_TIMEWAIT_EXPIRE: ok = move_if(PH_TIME_WAIT, PH_CLOSED);
            OP_RESET:
            begin
                trk_phase = PH_CLOSED;
                ok = 1'b1;
            end
            OP_TIMEOUT:
            begin
                if (trk_phase != PH_CLOSED && trk_phase != PH_ESTABLISHED)
                begin
                    trk_phase = PH_CLOSED;
                    ok = 1'b1;
                end
            end
            OP_REFRESH:
            begin
                trk_idle = '0;
                ok = 1'b1;
            end
            OP_WINDOW_UPDATE:
            begin
                trk_window = (amt < trk_rx_window) ? amt : trk_rx_window;
                ok = 1'b1;
            end
            OP_SEND:
            begin
                if (amt <= trk_window)
                begin
                    trk_window = trk_window - amt;
                    trk_idle = '0;
                    ok = 1'b1;
                end
            end
            OP_RECEIVE:
            begin
                if (trk_phase == PH_ESTABLISHED)
                begin
                    trk_idle = '0;
                    ok = 1'b1;
                end
            end
            OP_TICK:
            begin
                // saturate rather than wrap
                if (trk_idle != '1)
                    trk_idle = trk_idle + 1'b1;
                ok = 1'b1;
            end
            default: ;
        endcase
        res.accepted = ok;
        res.phase    = trk_phase;
        res.window   = trk_window;
        res.alive    = (int'(trk_idle) <= int'(trk_keepalive) + GRACE_MS_DEF);
        return res;
    endfunction

    // pick an event that moves the connection along from where it stands
    function automatic logic [3:0] next_legal_op();
        logic [3:0] op;
        case (trk_phase)
            PH_CLOSED:     op = ($urandom_range(0, 1) != 0) ? OP_OPEN : OP_SYN;
            PH_SYN_SENT:   op = OP_SYNACK;
            PH_SYN_RCVD:   op = OP_ACK;
            PH_ESTABLISHED:
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2: op = OP_SEND;
                    3, 4:    op = OP_RECEIVE;
                    5:       op = OP_WINDOW_UPDATE;
                    6:       op = OP_REFRESH;
                    7:       op = OP_CLOSE_REQ;
                    8:       op = OP_FIN;
                    default: op = OP_TICK;
                endcase
            end
            PH_FIN_WAIT1:  op = ($urandom_range(0, 1) != 0) ? OP_ACK : OP_FIN;
            PH_FIN_WAIT2:  op = OP_FIN;
            PH_CLOSE_WAIT: op = OP_PASSIVE_CLOSE;
            PH_CLOSING:    op = OP_ACK;
            PH_LAST_ACK:   op = OP_ACK;
            PH_TIME_WAIT:  op = OP_TIMEWAIT_EXPIRE;
            default:       op = OP_RESET;
        endcase
        return op;
    endfunction

    function automatic logic [AMT_W-1:0] pick_amount(logic [3:0] op);
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (op == OP_SEND)
        begin
            if (sel < 6)
                return $urandom_range(0, trk_window >> $urandom_range(0, 8));
            if (sel == 6)
                return trk_window + 1'b1;
            if (sel == 7)
                return trk_window;
        end
        else if (op == OP_WINDOW_UPDATE)
        begin
            if (sel < 3)
                return trk_rx_window;
            if (sel == 3)
                return '0;
            if (sel == 4)
                return '1;
            if (sel < 7)
                return $urandom_range(0, trk_rx_window);
        end
        return $urandom;
    endfunction

    task automatic send_request(logic [3:0] op, logic [AMT_W-1:0] amt);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        in_valid <= 1'b1;
        opcode   <= op;
        amount   <= amt;
        do @(posedge clk); while (in_stall);
        pending_results.push_back(apply_event(op, amt));
    endtask

    // stop offering, wait for every result and let the pipeline settle
    task automatic drain_requests();
        @(negedge clk);
        in_valid <= 1'b0;
        burst_left = 0;
        wait (pending_results.size() == 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        drain_requests();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_RECEIVE_WINDOW:
            begin
                trk_rx_window = data;
                trk_window    = data;
            end
            CFG_KEEPALIVE_MS:
            begin
                trk_keepalive = data[KEEP_W-1:0];
                trk_idle      = '0;
            end
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_requests(int count, int tick_pct);
        logic [3:0]  op;
        int unsigned r;
        repeat (count)
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
                op = next_legal_op();
            else if (r < 55 + tick_pct)
                op = OP_TICK;
            else
                op = 4'($urandom_range(0, 15));
            send_request(op, pick_amount(op));
        end
    endtask

    task automatic test_connection_paths();
        logic [3:0] path [23] = '{
            OP_UNUSED, OP_TIMEOUT, OP_TIMEWAIT_EXPIRE, OP_RECEIVE, OP_ACK,
            OP_OPEN, OP_OPEN, OP_SYNACK, OP_TIMEOUT, OP_RECEIVE,
            OP_CLOSE_REQ, OP_FIN, OP_ACK, OP_TIMEWAIT_EXPIRE,
            OP_SYN, OP_ACK, OP_FIN, OP_PASSIVE_CLOSE, OP_ACK,
            OP_OPEN, OP_TIMEOUT, OP_CLOSE_REQ, OP_RESET
        };
        gap_max = 0;
        foreach (path[i])
            send_request(path[i], $urandom);
    endtask

    task automatic test_window_limits();
        write_register(CFG_RECEIVE_WINDOW, 32'd1000);
        send_request(OP_SEND, 32'd1001);
        send_request(OP_SEND, 32'd0);
        send_request(OP_SEND, 32'd1000);
        send_request(OP_SEND, 32'd1);
        send_request(OP_WINDOW_UPDATE, 32'hFFFF_FFFF);
        send_request(OP_WINDOW_UPDATE, 32'd7);
        send_request(OP_SEND, 32'hFFFF_FFFF);
        send_request(OP_WINDOW_UPDATE, 32'd0);
    endtask

    // interval of zero: alive holds up to the grace period and drops one tick later
    task automatic test_idle_limit();
        write_register(CFG_KEEPALIVE_MS, 32'hFF00_0000);
        repeat (GRACE_MS_DEF + 3) send_request(OP_TICK, $urandom);
        send_request(OP_REFRESH, $urandom);
        repeat (GRACE_MS_DEF + 2) send_request(OP_TICK, $urandom);
        write_register(CFG_KEEPALIVE_MS, 32'd1);
        send_request(OP_TICK, $urandom);
    endtask

    task automatic test_backpressure();
        write_register(CFG_RECEIVE_WINDOW, 32'h0010_0000);
        gap_max = 0;
        hold_off_request = 300;
        random_requests(40, 15);
    endtask

    task automatic test_random_traffic(logic [WIN_W-1:0] win, logic [CFG_DATA_W-1:0] keep,
                                       int count, int tick_pct);
        write_register(($urandom_range(0, 1) != 0) ? CFG_SPARE_LO : CFG_SPARE_HI, $urandom);
        write_register(CFG_RECEIVE_WINDOW, win);
        write_register(CFG_KEEPALIVE_MS, keep);
        for (int done = 0; done < count; done += 100)
        begin
            gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            random_requests((count - done < 100) ? count - done : 100, tick_pct);
        end
    endtask

    // receiver stall pattern: changes mode now and then, or holds off on request
    initial
    begin : result_stall
        int mode = 0;
        int mode_left = 0;
        int hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_off_request > 0)
            begin
                hold_left = hold_off_request;
                hold_off_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(16, 96);
                end
                mode_left--;
                case (mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 3) == 0);
                    2:       out_stall <= ($urandom_range(0, 9) < 6);
                    default: out_stall <= (mode_left % 3 == 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        result_t exp_res;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no request outstanding: conn_state %0d window %0h",
                       conn_state, available_window);
                errors++;
            end
            else
            begin
                exp_res = pending_results.pop_front();
                if (accepted !== exp_res.accepted)
                begin
                    $error("accepted: expected %0b, got %0b", exp_res.accepted, accepted);
                    errors++;
                end
                if (conn_state !== exp_res.phase)
                begin
                    $error("conn_state: expected %0d, got %0d", exp_res.phase, conn_state);
                    errors++;
                end
                if (available_window !== exp_res.window)
                begin
                    $error("available_window: expected %0h, got %0h",
                           exp_res.window, available_window);
                    errors++;
                end
                if (alive !== exp_res.alive)
                begin
                    $error("alive: expected %0b, got %0b", exp_res.alive, alive);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        reset_tracking();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_connection_paths();
        test_window_limits();
        test_idle_limit();
        test_backpressure();
        test_random_traffic(32'hFFFF_FFFF, 32'hFFFF_FFFF, 400, 10);
        test_random_traffic(32'($urandom_range(0, 5000)), 32'd3, 400, 30);
        test_random_traffic(32'd0, 32'd0, 300, 20);
        test_random_traffic($urandom, $urandom, 400, 10);

        drain_requests();
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
